@@ src/sqmc_pkg.sv @@
// Shared types and constants for the segment query memo cache.
`timescale 1ns / 1ps
package sqmc_pkg;

  localparam int KEY_WORDS     = 7;
  localparam int WORD_BITS     = 32;
  localparam int KEY_BITS      = KEY_WORDS * WORD_BITS;
  localparam int HIDX_BITS     = 32;

  localparam logic [63:0] FNV_OFFSET = 64'd1469598103934665603;
  localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
  localparam logic [63:0] MIX_MULT   = 64'h9e3779b97f4a7c15;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] CLASS_SIGHT = 2'd0;

  localparam logic [1:0] VERDICT_EMPTY   = 2'd0;
  localparam logic [1:0] VERDICT_CLEAR   = 2'd1;
  localparam logic [1:0] VERDICT_BLOCKED = 2'd2;

  typedef logic [KEY_BITS-1:0] key_t;

  // One classified request on its way from the hash front to the tables.
  typedef struct packed {
    logic [1:0]           kind;
    logic [1:0]           cls;
    key_t                 key;
    logic                 verdict;
    logic [HIDX_BITS-1:0] hidx;
  } work_t;

endpackage

@@ src/sqmc_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface sqmc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  line_class;
  logic [31:0] start_x_bits;
  logic [31:0] start_y_bits;
  logic [31:0] start_z_bits;
  logic [31:0] end_x_bits;
  logic [31:0] end_y_bits;
  logic [31:0] end_z_bits;
  logic [31:0] padding_bits;
  logic        clear_verdict;
  modport source (output valid, kind, line_class, start_x_bits, start_y_bits, start_z_bits,
                  end_x_bits, end_y_bits, end_z_bits, padding_bits, clear_verdict,
                  input ready);
  modport sink (input valid, kind, line_class, start_x_bits, start_y_bits, start_z_bits,
                end_x_bits, end_y_bits, end_z_bits, padding_bits, clear_verdict,
                output ready);
endinterface

interface sqmc_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic is_clear;
  modport source (output valid, hit, is_clear, input ready);
  modport sink (input valid, hit, is_clear, output ready);
endinterface

@@ src/segment_query_memo_cache.sv @@
// Top level of the segment query memo cache.
// Only a lookup gives a response; a new request is taken only once the last one is queued.
// A lookup or fill key is hashed with nine 64-bit multiplies, three 32x32 passes each.
// A flush clears the tag memories, sweeping 2**max(index bits) addresses while the back end stalls.
// Reset is synchronous; afterwards the same sweep runs and no request is accepted until it ends.
`timescale 1ns / 1ps
module segment_query_memo_cache
  import sqmc_pkg::*;
#(
  parameter int SIGHT_INDEX_BITS = 10,
  parameter int OTHER_INDEX_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  sqmc_req_if.sink   req,
  sqmc_rsp_if.source rsp
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  logic  booting;
  work_t q_wdata;
  work_t q_rdata;

  sqmc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .hold   (booting),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  sqmc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sqmc_back #(
    .SIGHT_INDEX_BITS (SIGHT_INDEX_BITS),
    .OTHER_INDEX_BITS (OTHER_INDEX_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .booting (booting),
    .rsp     (rsp)
  );

  a_miss_not_clear: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> !rsp.is_clear)
    else $error("miss reported with a clear verdict");

  a_boot_blocks: assert property (@(posedge clk) disable iff (rst)
    booting |-> !req.ready)
    else $error("request accepted during the reset sweep");

  a_queue_safe: assert property (@(posedge clk) disable iff (rst)
    (q_full |-> !q_push) and (q_empty |-> !q_pop))
    else $error("queue overflow or underflow");

endmodule

@@ src/sqmc_front.sv @@
// Request front end: accepts requests and hashes the key with a shared 32x32 multiplier.
`timescale 1ns / 1ps
module sqmc_front
  import sqmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sqmc_req_if.sink   req,
  input  logic       hold,
  input  logic       q_full,
  output logic       q_push,
  output work_t      q_data
);

  typedef enum logic [1:0] {IDLE, MUL, PUSH} state_t;

  state_t                 state;
  logic [1:0]             kind;
  logic [1:0]             cls;
  logic [WORD_BITS-1:0]   words [KEY_WORDS];
  logic                   verdict;
  logic [63:0]            x;
  logic [63:0]            acc;
  logic [63:0]            h;
  logic [3:0]             step;
  logic [1:0]             phase;

  logic [63:0] cmul;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;
  logic [63:0] r;
  logic [2:0]  widx;
  logic [63:0] x_next;
  key_t        key;

  assign cmul = (step == 4'd8) ? MIX_MULT : FNV_PRIME;
  assign ma   = (phase == 2'd2) ? x[63:32] : x[31:0];
  assign mb   = (phase == 2'd1) ? cmul[63:32] : cmul[31:0];
  assign prod = {32'd0, ma} * {32'd0, mb};
  assign r    = acc + {prod[31:0], 32'd0};
  assign widx = step[2:0] + 3'd1;

  always_comb begin
    priority if (step < 4'd6) begin
      x_next = r ^ {32'd0, words[widx]};
    end else if (step == 4'd6) begin
      x_next = r ^ {62'd0, cls};
    end else begin
      x_next = r ^ {32'd0, r[63:32]};
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) begin
      key[i*WORD_BITS +: WORD_BITS] = words[i];
    end
  end

  assign req.ready = (state == IDLE) && !hold;
  assign q_push    = (state == PUSH) && !q_full;
  assign q_data    = '{kind: kind, cls: cls, key: key, verdict: verdict,
                       hidx: h[HIDX_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
      phase <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (req.valid && req.ready) begin
            kind     <= req.kind;
            cls      <= req.line_class;
            verdict  <= req.clear_verdict;
            words[0] <= req.start_x_bits;
            words[1] <= req.start_y_bits;
            words[2] <= req.start_z_bits;
            words[3] <= req.end_x_bits;
            words[4] <= req.end_y_bits;
            words[5] <= req.end_z_bits;
            words[6] <= req.padding_bits;
            x        <= FNV_OFFSET ^ {32'd0, req.start_x_bits};
            step     <= '0;
            phase    <= '0;
            priority if (req.kind == KIND_FLUSH) begin
              state <= PUSH;
            end else if (req.kind == KIND_NONE) begin
              state <= IDLE;
            end else begin
              state <= MUL;
            end
          end
        end
        MUL: begin
          unique case (phase)
            2'd0: begin
              acc   <= prod;
              phase <= 2'd1;
            end
            2'd1: begin
              acc   <= r;
              phase <= 2'd2;
            end
            default: begin
              phase <= 2'd0;
              if (step == 4'd8) begin
                h     <= r ^ {29'd0, r[63:29]};
                state <= PUSH;
              end else begin
                x    <= x_next;
                step <= step + 4'd1;
              end
            end
          endcase
        end
        default: begin
          if (!q_full) state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/sqmc_queue.sv @@
// Two-entry queue between the hash front end and the table back end.
`timescale 1ns / 1ps
module sqmc_queue
  import sqmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t wdata,
  output logic  full,
  input  logic  pop,
  output work_t rdata,
  output logic  empty
);

  work_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/sqmc_back.sv @@
// Table back end: tag and key memories, lookups, fills and the clearing sweep.
`timescale 1ns / 1ps
module sqmc_back
  import sqmc_pkg::*;
#(
  parameter int SIGHT_INDEX_BITS = 10,
  parameter int OTHER_INDEX_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  work_t      q_data,
  output logic       q_pop,
  output logic       booting,
  sqmc_rsp_if.source rsp
);

  localparam int CW = (SIGHT_INDEX_BITS > OTHER_INDEX_BITS) ? SIGHT_INDEX_BITS
                                                            : OTHER_INDEX_BITS;

  typedef enum logic [1:0] {CLEAR, IDLE, RESP} state_t;

  logic [3:0] sight_tags      [2**SIGHT_INDEX_BITS];
  key_t       sight_key_words [2**SIGHT_INDEX_BITS];
  logic [3:0] other_tags      [2**OTHER_INDEX_BITS];
  key_t       other_key_words [2**OTHER_INDEX_BITS];

  state_t                      state;
  logic [CW-1:0]               cnt;
  logic [1:0]                  cls;
  key_t                        key;
  logic [3:0]                  stag_q;
  logic [3:0]                  otag_q;
  key_t                        skey_q;
  key_t                        okey_q;

  logic [SIGHT_INDEX_BITS-1:0] sidx;
  logic [OTHER_INDEX_BITS-1:0] oidx;
  logic                        take;
  logic                        is_sight;
  logic                        do_fill;
  logic                        do_read;
  logic [3:0]                  fill_tag;
  logic [3:0]                  tag;
  logic                        hit_now;
  logic                        out_free;

  assign take     = (state == IDLE) && !q_empty;
  assign q_pop    = take;
  assign is_sight = (q_data.cls == CLASS_SIGHT);
  assign do_fill  = take && (q_data.kind == KIND_FILL);
  assign do_read  = take && (q_data.kind == KIND_LOOKUP);
  assign fill_tag = {q_data.cls, q_data.verdict ? VERDICT_CLEAR : VERDICT_BLOCKED};
  assign sidx     = (state == CLEAR) ? cnt[SIGHT_INDEX_BITS-1:0]
                                     : q_data.hidx[SIGHT_INDEX_BITS-1:0];
  assign oidx     = (state == CLEAR) ? cnt[OTHER_INDEX_BITS-1:0]
                                     : q_data.hidx[OTHER_INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (state == CLEAR) begin
      sight_tags[sidx] <= '0;
      other_tags[oidx] <= '0;
    end else if (do_fill) begin
      if (is_sight) begin
        sight_tags[sidx]      <= fill_tag;
        sight_key_words[sidx] <= q_data.key;
      end else begin
        other_tags[oidx]      <= fill_tag;
        other_key_words[oidx] <= q_data.key;
      end
    end
    if (do_read) begin
      stag_q <= sight_tags[sidx];
      skey_q <= sight_key_words[sidx];
      otag_q <= other_tags[oidx];
      okey_q <= other_key_words[oidx];
    end
  end

  assign tag      = (cls == CLASS_SIGHT) ? stag_q : otag_q;
  assign hit_now  = (tag[1:0] != VERDICT_EMPTY) && (tag[3:2] == cls) &&
                    (((cls == CLASS_SIGHT) ? skey_q : okey_q) == key);
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      cnt       <= '0;
      booting   <= 1'b1;
      rsp.valid <= 1'b0;
    end else begin
      // In RESP with a free output the new response replaces the old one.
      if (rsp.valid && rsp.ready && (state != RESP)) rsp.valid <= 1'b0;
      unique case (state)
        CLEAR: begin
          cnt <= cnt + 1'b1;
          if (&cnt) begin
            state   <= IDLE;
            booting <= 1'b0;
          end
        end
        IDLE: begin
          if (take) begin
            cls <= q_data.cls;
            key <= q_data.key;
            priority if (q_data.kind == KIND_FLUSH) begin
              cnt   <= '0;
              state <= CLEAR;
            end else if (q_data.kind == KIND_LOOKUP) begin
              state <= RESP;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: begin
          if (out_free) begin
            rsp.valid    <= 1'b1;
            rsp.hit      <= hit_now;
            rsp.is_clear <= hit_now && (tag[1:0] == VERDICT_CLEAR);
            state        <= IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the segment query memo cache.
`timescale 1ns / 1ps
module tb;
  import sqmc_pkg::*;

  localparam int SIGHT_BITS = 10;
  localparam int OTHER_BITS = 12;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  cls;
    logic [31:0] words [KEY_WORDS];
    logic        verdict;
  } query_t;

  typedef struct {
    logic hit;
    logic is_clear;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sqmc_req_if req ();
  sqmc_rsp_if rsp ();

  segment_query_memo_cache #(
    .SIGHT_INDEX_BITS(SIGHT_BITS),
    .OTHER_INDEX_BITS(OTHER_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the two tables.
  logic [3:0]  sight_tag [1 << SIGHT_BITS];
  logic [31:0] sight_key [1 << SIGHT_BITS][KEY_WORDS];
  logic [3:0]  other_tag [1 << OTHER_BITS];
  logic [31:0] other_key [1 << OTHER_BITS][KEY_WORDS];

  answer_t expected_answers[$];
  int      error_count = 0;
  bit      hold_rsp = 1'b0;
  bit      no_idle = 1'b0;

  // A pool of keys already filled, so that lookups hit often.
  query_t  filled_keys[$];

  function automatic logic [63:0] key_hash(query_t q);
    logic [63:0] h;
    h = FNV_OFFSET;
    for (int i = 0; i < KEY_WORDS; i++) h = (h ^ {32'd0, q.words[i]}) * FNV_PRIME;
    h = (h ^ {62'd0, q.cls}) * FNV_PRIME;
    h ^= h >> 32;
    h *= MIX_MULT;
    h ^= h >> 29;
    return h;
  endfunction

  function automatic void flush_tables();
    foreach (sight_tag[i]) sight_tag[i] = 4'd0;
    foreach (other_tag[i]) other_tag[i] = 4'd0;
  endfunction

  function automatic void predict_query(query_t q);
    logic [63:0] h;
    logic [3:0]  t;
    logic        same;
    int          idx;
    answer_t     a;
    if (q.kind == KIND_FLUSH) begin
      flush_tables();
      filled_keys.delete();
      return;
    end
    if (q.kind == KIND_NONE) return;
    h = key_hash(q);
    idx = (q.cls == CLASS_SIGHT) ? int'(h[SIGHT_BITS-1:0]) : int'(h[OTHER_BITS-1:0]);
    if (q.kind == KIND_FILL) begin
      t = {q.cls, q.verdict ? VERDICT_CLEAR : VERDICT_BLOCKED};
      if (q.cls == CLASS_SIGHT) begin
        sight_tag[idx] = t;
        for (int i = 0; i < KEY_WORDS; i++) sight_key[idx][i] = q.words[i];
      end else begin
        other_tag[idx] = t;
        for (int i = 0; i < KEY_WORDS; i++) other_key[idx][i] = q.words[i];
      end
      filled_keys.insert(filled_keys.size(), q);
      if (filled_keys.size() > 64) void'(filled_keys.pop_front());
      return;
    end
    same = 1'b1;
    if (q.cls == CLASS_SIGHT) begin
      t = sight_tag[idx];
      if (t[1:0] != VERDICT_EMPTY)
        for (int i = 0; i < KEY_WORDS; i++) if (sight_key[idx][i] != q.words[i]) same = 1'b0;
    end else begin
      t = other_tag[idx];
      if (t[1:0] != VERDICT_EMPTY)
        for (int i = 0; i < KEY_WORDS; i++) if (other_key[idx][i] != q.words[i]) same = 1'b0;
    end
    a.hit = (t[1:0] != VERDICT_EMPTY) && (t[3:2] == q.cls) && same;
    a.is_clear = a.hit && (t[1:0] == VERDICT_CLEAR);
    expected_answers.insert(expected_answers.size(), a);
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic idle_burst();
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  // The valid line stays high between back-to-back requests unless a random idle burst comes in between.
  task automatic send_query(query_t q);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      idle_burst();
    end
    req.valid         <= 1'b1;
    req.kind          <= q.kind;
    req.line_class    <= q.cls;
    req.start_x_bits  <= q.words[0];
    req.start_y_bits  <= q.words[1];
    req.start_z_bits  <= q.words[2];
    req.end_x_bits    <= q.words[3];
    req.end_y_bits    <= q.words[4];
    req.end_z_bits    <= q.words[5];
    req.padding_bits  <= q.words[6];
    req.clear_verdict <= q.verdict;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_query(q);
  endtask

  // Response side: checking against the oldest prediction, then random stalls or a hold of the ready line.
  initial begin
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected response", rsp.valid, 1'b0);
        end else begin
          answer_t a;
          a = expected_answers.pop_front();
          if (rsp.hit !== a.hit) report_mismatch("hit", rsp.hit, a.hit);
          if (rsp.is_clear !== a.is_clear) report_mismatch("is_clear", rsp.is_clear, a.is_clear);
        end
      end
      if (hold_rsp) rsp.ready <= 1'b0;
      else if (!no_idle && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        rsp.ready <= 1'b1;
      end else rsp.ready <= 1'b1;
    end
  end

  function automatic query_t random_query(logic [1:0] kind);
    query_t q;
    q.kind = kind;
    q.cls = 2'($urandom_range(0, 3));
    for (int i = 0; i < KEY_WORDS; i++) q.words[i] = $urandom;
    q.verdict = 1'($urandom);
    return q;
  endfunction

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_directed();
    query_t q;
    for (int c = 0; c < 4; c++) begin
      q = random_query(KIND_LOOKUP);
      q.cls = 2'(c);
      for (int i = 0; i < KEY_WORDS; i++) q.words[i] = (c % 2) ? 32'hFFFF_FFFF : 32'd0;
      send_query(q);
      q.kind = KIND_FILL;
      q.verdict = 1'(c);
      send_query(q);
      q.kind = KIND_LOOKUP;
      send_query(q);
      // Same words under another class must miss.
      q.cls = 2'(c ^ 1);
      send_query(q);
    end
    q = random_query(KIND_NONE);
    send_query(q);
    q = random_query(KIND_FLUSH);
    send_query(q);
    q = random_query(KIND_LOOKUP);
    q.cls = CLASS_SIGHT;
    for (int i = 0; i < KEY_WORDS; i++) q.words[i] = 32'd0;
    send_query(q);
  endtask

  task automatic random_step();
    query_t q;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && filled_keys.size() != 0) begin
      q = filled_keys[$urandom_range(0, filled_keys.size() - 1)];
      q.kind = KIND_LOOKUP;
      // Sometimes disturb one bit so that near matches miss.
      if ($urandom_range(0, 4) == 0) q.words[$urandom_range(0, 6)] ^= 32'(1) << $urandom_range(0, 31);
    end else if (r < 75) q = random_query(KIND_FILL);
    else if (r < 96) q = random_query(KIND_LOOKUP);
    else if (r < 98) q = random_query(KIND_NONE);
    else q = random_query(KIND_FLUSH);
    send_query(q);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) random_step();
  endtask

  task automatic test_backpressure();
    hold_rsp = 1'b1;
    fork
      begin
        for (int n = 0; n < 30; n++) begin
          query_t q;
          q = random_query(KIND_LOOKUP);
          send_query(q);
        end
      end
      begin
        repeat (2000) @(posedge clk);
        hold_rsp = 1'b0;
      end
    join
  endtask

  initial begin
    req.valid = 1'b0;
    req.kind = KIND_LOOKUP;
    req.line_class = CLASS_SIGHT;
    req.start_x_bits = '0;
    req.start_y_bits = '0;
    req.start_z_bits = '0;
    req.end_x_bits = '0;
    req.end_y_bits = '0;
    req.end_z_bits = '0;
    req.padding_bits = '0;
    req.clear_verdict = 1'b0;
    flush_tables();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(700);
    no_idle = 1'b1;
    test_random(200);
    wait_drained();
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
